/* hdl/rv32ia_pkg.sv */
// shared types, decode codes and queue sizes for the immediate alu core
package rv32ia_pkg;

    // instruction encodings
    localparam logic [6:0]  OPC_IMM_ALU = 7'b0010011;
    localparam logic [31:0] WORD_EBREAK = 32'h00100073;
    localparam logic [2:0]  F3_ADD      = 3'b000;
    localparam logic [2:0]  F3_XOR      = 3'b100;
    localparam logic [2:0]  F3_OR       = 3'b110;
    localparam logic [2:0]  F3_AND      = 3'b111;

    // ebreak command registers
    localparam logic [4:0]  REG_A0 = 5'd10;
    localparam logic [4:0]  REG_A1 = 5'd11;

    // register file
    localparam int RF_DEPTH = 32;
    localparam int RF_IDX_W = $clog2(RF_DEPTH);

    // decoded request queue between front and back (depth a power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // result queue in the back end (two entries)
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        K_ALU,
        K_BAD_F3,
        K_EBREAK,
        K_UNSUP
    } t_kind;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_XOR,
        OP_OR,
        OP_AND
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_F3,
        ST_UNSUP,
        ST_BAD_EBREAK,
        ST_IGNORED
    } t_status;

    typedef struct packed {
        t_kind                kind;
        t_alu_op              op;
        logic [RF_IDX_W-1:0]  rd;
        logic [RF_IDX_W-1:0]  rs1;
        logic [11:0]          imm;
    } t_dec;

    typedef struct packed {
        t_status      status;
        logic         char_valid;
        logic [7:0]   char_byte;
        logic         halted;
        logic [31:0]  addr;
    } t_res;

endpackage

/* hdl/rv32_immediate_alu_core.sv */
// top level of the immediate alu core: front, decoded queue and back
//
//  channel   handshake              payload
//  input     push / full            i_instruction_word
//  result    empty / pop            o_status_code, o_char_valid, o_char_byte,
//                                   o_halted, o_instr_address
//
// one request per cycle sustained while neither queue is full; an accepted
// request is written into the decoded queue, executed from there by the back
// end (register file read, alu and writeback), and its result is registered in
// the result queue, from which it can be popped.
// the front takes requests while the four-entry decoded queue has room, and
// the back runs while the two-entry result queue has room or is being popped.
// synchronous active-low reset clears the register file, counter, halt flag
// and both queues.
module rv32_immediate_alu_core
    import rv32ia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_instruction_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status_code,
    output logic        o_char_valid,
    output logic [7:0]  o_char_byte,
    output logic        o_halted,
    output logic [31:0] o_instr_address
);

    t_dec q_in;
    t_dec q_out;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_res res;

    // classify incoming requests
    rv32ia_front u_front (
        .push               (push),
        .full               (full),
        .i_instruction_word (i_instruction_word),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_data           (q_in)
    );

    // decouple front and back
    rv32ia_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // execute and queue results
    rv32ia_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dec     (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_res     (res)
    );

    // result fields
    assign o_status_code   = 3'(res.status);
    assign o_char_valid    = res.char_valid;
    assign o_char_byte     = res.char_byte;
    assign o_halted        = res.halted;
    assign o_instr_address = res.addr;

endmodule

/* hdl/rv32ia_front.sv */
// front end: accepts instruction requests and classifies them
module rv32ia_front
    import rv32ia_pkg::*;
(
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_instruction_word,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_dec        o_q_data
);

    logic [6:0] opcode;
    logic [2:0] f3;

    assign opcode = i_instruction_word[6:0];
    assign f3     = i_instruction_word[14:12];

    // accept while the decoded queue has room
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    // decode into kind and alu operation
    always_comb begin
        o_q_data.rd  = i_instruction_word[11:7];
        o_q_data.rs1 = i_instruction_word[19:15];
        o_q_data.imm = i_instruction_word[31:20];
        o_q_data.op  = OP_ADD;
        if (opcode == OPC_IMM_ALU) begin
            o_q_data.kind = K_ALU;
            unique case (f3)
                F3_ADD: o_q_data.op = OP_ADD;
                F3_XOR: o_q_data.op = OP_XOR;
                F3_OR:  o_q_data.op = OP_OR;
                F3_AND: o_q_data.op = OP_AND;
                default: begin
                    o_q_data.kind = K_BAD_F3;
                end
            endcase
        end else if (i_instruction_word == WORD_EBREAK) begin
            o_q_data.kind = K_EBREAK;
        end else begin
            o_q_data.kind = K_UNSUP;
        end
    end

endmodule

/* hdl/rv32ia_fifo.sv */
// small queue of decoded requests between front and back
module rv32ia_fifo
    import rv32ia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_data,
    output logic o_full,
    input  logic i_pop,
    output t_dec o_data,
    output logic o_empty
);

    t_dec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    // queue sanity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("decoded queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full decoded queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty decoded queue");

endmodule

/* hdl/rv32ia_back.sv */
// back end: register file, execute, program counter, halt and result queue
module rv32ia_back
    import rv32ia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_dec i_dec,
    input  logic i_q_empty,
    output logic o_q_pop,
    input  logic pop,
    output logic empty,
    output t_res o_res
);

    logic [31:0]          r_rf [RF_DEPTH];
    logic [31:0]          r_pc;
    logic                 r_halted;
    t_res                 r_res [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr;
    logic [RES_PTR_W-1:0] r_rd;
    logic [RES_CNT_W-1:0] r_cnt;

    logic [31:0] src_a;
    logic [31:0] imm_x;
    logic [31:0] alu_y;
    logic [31:0] cmd;
    logic [31:0] n_pc;
    logic        n_halted;
    logic        rf_we;
    logic        res_pop;
    logic        do_exec;
    t_res        res;

    // result queue handshake
    assign res_pop = pop && (r_cnt != '0);
    assign empty   = (r_cnt == '0);
    assign o_res   = r_res[r_rd];
    assign do_exec = !i_q_empty && ((r_cnt != RES_CNT_W'(RES_DEPTH)) || res_pop);
    assign o_q_pop = do_exec;

    // operand fetch and alu
    assign src_a = r_rf[i_dec.rs1];
    assign imm_x = {{20{i_dec.imm[11]}}, i_dec.imm};
    assign cmd   = r_rf[REG_A0];

    always_comb begin
        case (i_dec.op)
            OP_ADD:  alu_y = src_a + imm_x;
            OP_XOR:  alu_y = src_a ^ imm_x;
            OP_OR:   alu_y = src_a | imm_x;
            OP_AND:  alu_y = src_a & imm_x;
            default: alu_y = src_a + imm_x;
        endcase
    end

    // execute: status, console byte, halt and counter
    always_comb begin
        res.status     = ST_OK;
        res.char_valid = 1'b0;
        res.char_byte  = 8'd0;
        res.addr       = r_pc;
        n_halted       = r_halted;
        n_pc           = r_pc;
        rf_we          = 1'b0;
        if (r_halted) begin
            res.status = ST_IGNORED;
        end else begin
            n_pc = r_pc + 32'd4;
            unique case (i_dec.kind)
                K_ALU: begin
                    rf_we = (i_dec.rd != '0);
                end
                K_BAD_F3: begin
                    res.status = ST_BAD_F3;
                end
                K_EBREAK: begin
                    if (cmd == 32'd0) begin
                        res.char_valid = 1'b1;
                        res.char_byte  = r_rf[REG_A1][7:0];
                    end else if (cmd == 32'd1) begin
                        n_halted = 1'b1;
                    end else begin
                        res.status = ST_BAD_EBREAK;
                    end
                end
                K_UNSUP: begin
                    res.status = ST_UNSUP;
                end
                default: begin
                    res.status = ST_UNSUP;
                end
            endcase
        end
        res.halted = n_halted;
    end

    // register file, x0 never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RF_DEPTH; k++) begin
                r_rf[k] <= '0;
            end
        end else if (do_exec && rf_we) begin
            r_rf[i_dec.rd] <= alu_y;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_halted <= 1'b0;
        end else if (do_exec) begin
            r_pc     <= n_pc;
            r_halted <= n_halted;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_res[r_wr] <= res;
        end
    end

    // result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_exec) begin
                r_wr <= r_wr + RES_PTR_W'(1);
            end
            if (res_pop) begin
                r_rd <= r_rd + RES_PTR_W'(1);
            end
            if (do_exec && !res_pop) begin
                r_cnt <= r_cnt + RES_CNT_W'(1);
            end else if (!do_exec && res_pop) begin
                r_cnt <= r_cnt - RES_CNT_W'(1);
            end
        end
    end

    // state invariants
    a_x0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rf[0] == 32'd0)
        else $error("x0 holds a nonzero value");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_exec && r_halted) |=> $stable(r_pc))
        else $error("counter moved after halt");
    a_res_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count out of range");

endmodule

/* tb/rv32_immediate_alu_core_checker.sv */
// checker for the immediate alu core: predicts each request's result and compares
module rv32_immediate_alu_core_checker
    import rv32ia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_instruction_word,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_status_code,
    input  logic        i_char_valid,
    input  logic [7:0]  i_char_byte,
    input  logic        i_halted,
    input  logic [31:0] i_instr_address,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_LIMIT = 10;

    // predicted architectural state
    logic [31:0] gpr [RF_DEPTH];
    logic [31:0] pc_model;
    logic        halt_model;

    // results still owed by the block, oldest first
    t_res        owed_results [$];
    int          fail_count;

    // run one instruction word on the predicted state and queue its result
    task automatic execute_word(input logic [31:0] w);
        t_res        res;
        logic [31:0] imm_sx;
        logic [31:0] src;
        logic [31:0] value;
        logic        legal;
        res        = '0;
        res.status = ST_OK;
        res.addr   = pc_model;
        if (halt_model) begin
            res.status = ST_IGNORED;
        end else begin
            imm_sx = {{20{w[31]}}, w[31:20]};
            src    = gpr[w[19:15]];
            value  = '0;
            legal  = 1'b1;
            if (w[6:0] == OPC_IMM_ALU) begin
                case (w[14:12])
                    F3_ADD:  value = src + imm_sx;
                    F3_XOR:  value = src ^ imm_sx;
                    F3_OR:   value = src | imm_sx;
                    F3_AND:  value = src & imm_sx;
                    default: legal = 1'b0;
                endcase
                // writes to x0 are dropped
                if (!legal) begin
                    res.status = ST_BAD_F3;
                end else if (w[11:7] != 5'd0) begin
                    gpr[w[11:7]] = value;
                end
            end else if (w == WORD_EBREAK) begin
                // a0 selects console output, halt or an error
                if (gpr[REG_A0] == 32'd0) begin
                    res.char_valid = 1'b1;
                    res.char_byte  = gpr[REG_A1][7:0];
                end else if (gpr[REG_A0] == 32'd1) begin
                    halt_model = 1'b1;
                end else begin
                    res.status = ST_BAD_EBREAK;
                end
            end else begin
                res.status = ST_UNSUP;
            end
            pc_model = pc_model + 32'd4;
        end
        res.halted = halt_model;
        owed_results.push_back(res);
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            for (int k = 0; k < RF_DEPTH; k++) gpr[k] = '0;
            pc_model   = '0;
            halt_model = 1'b0;
            owed_results.delete();
            fail_count = 0;
        end else begin
            // compare an accepted result with the oldest prediction
            if (i_pop && !i_empty) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] result with no request pending: status %0d addr %h",
                                 $time, i_status_code, i_instr_address);
                end else begin
                    want = owed_results.pop_front();
                    if (i_status_code !== want.status || i_char_valid !== want.char_valid ||
                        i_char_byte !== want.char_byte || i_halted !== want.halted ||
                        i_instr_address !== want.addr) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $write("[%0t] mismatch: status %0d/%0d char_valid %0d/%0d ",
                                   $time, want.status, i_status_code,
                                   want.char_valid, i_char_valid);
                            $display("char_byte %h/%h halted %0d/%0d addr %h/%h (exp/act)",
                                     want.char_byte, i_char_byte,
                                     want.halted, i_halted,
                                     want.addr, i_instr_address);
                        end
                    end
                end
            end
            // predict an accepted request
            if (i_push && !i_full)
                execute_word(i_instruction_word);
        end
        o_fail_count <= fail_count;
        o_pending    <= owed_results.size();
    end

endmodule

/* tb/rv32_immediate_alu_core_tb.sv */
// top of the immediate alu core testbench: clock, reset, request stimulus and verdict
module rv32_immediate_alu_core_tb
    import rv32ia_pkg::*;
();

    localparam int RANDOM_REQUESTS = 1800;
    localparam int STEADY_FIRST    = 700;
    localparam int STEADY_LAST     = 1000;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_instruction_word;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status_code;
    logic        o_char_valid;
    logic [7:0]  o_char_byte;
    logic        o_halted;
    logic [31:0] o_instr_address;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          sent;
    int          directed_count;
    logic        steady;

    rv32_immediate_alu_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_instruction_word (i_instruction_word),
        .empty              (empty),
        .pop                (pop),
        .o_status_code      (o_status_code),
        .o_char_valid       (o_char_valid),
        .o_char_byte        (o_char_byte),
        .o_halted           (o_halted),
        .o_instr_address    (o_instr_address)
    );

    rv32_immediate_alu_core_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_instruction_word (i_instruction_word),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_status_code      (o_status_code),
        .i_char_valid       (o_char_valid),
        .i_char_byte        (o_char_byte),
        .i_halted           (o_halted),
        .i_instr_address    (o_instr_address),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run-length guard
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // immediate alu instruction encoding
    function automatic logic [31:0] imm_op(input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [4:0] rs1, input logic [11:0] imm);
        imm_op = {imm, rs1, f3, rd, OPC_IMM_ALU};
    endfunction

    // hand one request over, with random idle cycles before it
    task automatic send_request(input logic [31:0] w);
        while (!steady && $urandom_range(99) < 21) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push               <= 1'b1;
        i_instruction_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        steady = (sent - directed_count >= STEADY_FIRST) &&
                 (sent - directed_count < STEADY_LAST);
    endtask

    // one random request or short sequence
    task automatic random_request();
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [11:0] imm;
        logic [31:0] w;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            // alu op, immediates leaning toward the extremes
            case ($urandom_range(7))
                0:       imm = 12'h800;
                1:       imm = 12'h7ff;
                2:       imm = 12'hfff;
                3:       imm = 12'h000;
                default: imm = 12'($urandom());
            endcase
            case ($urandom_range(4))
                0: f3 = F3_ADD;
                1: f3 = F3_XOR;
                2: f3 = F3_OR;
                3: f3 = F3_AND;
                default: f3 = 3'($urandom());
            endcase
            case ($urandom_range(9))
                0, 1:    rd = REG_A1;
                2:       rd = REG_A0;
                default: rd = 5'($urandom());
            endcase
            rs1 = ($urandom_range(3) == 0) ? REG_A1 : 5'($urandom());
            send_request(imm_op(f3, rd, rs1, imm));
        end else if (pick < 75) begin
            // load a0 with anything but the halt command, then ebreak
            imm = ($urandom_range(9) < 7) ? 12'h000 : 12'($urandom());
            if (imm == 12'h001) imm = 12'h002;
            send_request(imm_op(F3_ADD, REG_A0, 5'd0, imm));
            send_request(WORD_EBREAK);
        end else if (pick < 90) begin
            // arbitrary word, never an ebreak
            w = $urandom();
            if (w == WORD_EBREAK) w = ~w;
            send_request(w);
        end else begin
            // one bit off an ebreak or an alu op
            w = pick[0] ? WORD_EBREAK : imm_op(3'($urandom()), 5'($urandom()),
                                               5'($urandom()), 12'($urandom()));
            w[$urandom_range(31)] ^= 1'b1;
            if (w == WORD_EBREAK) w = ~w;
            send_request(w);
        end
    endtask

    // read side: pop with random idle cycles
    initial begin
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            pop <= steady || ($urandom_range(99) >= 21);
        end
    end

    // stimulus and verdict
    initial begin
        push               = 1'b0;
        i_instruction_word = '0;
        i_rst_n            = 1'b0;
        steady             = 1'b0;
        sent               = 0;
        directed_count     = 1 << 30;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // immediate extremes and every alu op
        send_request(imm_op(F3_ADD, 5'd1, 5'd0, 12'h800));
        send_request(imm_op(F3_ADD, 5'd2, 5'd0, 12'h7ff));
        send_request(imm_op(F3_XOR, 5'd3, 5'd1, 12'hfff));
        send_request(imm_op(F3_OR,  5'd4, 5'd2, 12'h800));
        send_request(imm_op(F3_AND, 5'd31, 5'd4, 12'h0f0));
        // add wraps, write to x0 dropped, x0 reads zero
        send_request(imm_op(F3_ADD, 5'd6, 5'd4, 12'h001));
        send_request(imm_op(F3_ADD, 5'd0, 5'd4, 12'h005));
        send_request(imm_op(F3_OR,  5'd7, 5'd0, 12'h000));
        // console output with a1 zero, 'A' and all ones
        send_request(WORD_EBREAK);
        send_request(imm_op(F3_ADD, REG_A1, 5'd0, 12'h041));
        send_request(WORD_EBREAK);
        send_request(imm_op(F3_ADD, REG_A1, 5'd4, 12'h000));
        send_request(WORD_EBREAK);
        // bad funct3 values
        send_request(imm_op(3'b001, 5'd8, 5'd4, 12'h123));
        send_request(imm_op(3'b010, 5'd8, 5'd4, 12'h123));
        send_request(imm_op(3'b011, 5'd8, 5'd4, 12'h123));
        send_request(imm_op(3'b101, 5'd8, 5'd4, 12'h123));
        // unsupported words
        send_request(32'h0000_0000);
        send_request(32'hffff_ffff);
        send_request(32'h0000_0073);
        send_request(32'h0020_0073);
        // bad ebreak commands
        send_request(imm_op(F3_ADD, REG_A0, 5'd0, 12'h002));
        send_request(WORD_EBREAK);
        send_request(imm_op(F3_ADD, REG_A0, 5'd0, 12'hfff));
        send_request(WORD_EBREAK);
        directed_count = sent;

        while (sent < directed_count + RANDOM_REQUESTS) random_request();

        // halt, then requests that must be ignored
        send_request(imm_op(F3_ADD, REG_A0, 5'd0, 12'h001));
        send_request(WORD_EBREAK);
        send_request(WORD_EBREAK);
        repeat (6) random_request();
        push <= 1'b0;

        // drain
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
